/* rtl/pca_pkg.sv */
// Shared types and constants for the price channel with alert unit.
// No dependencies; the top level and the checker refer to it by scoped names.
`timescale 1ns / 1ps

package pca_pkg;

    localparam int              CFG_W           = 7;
    localparam logic [6:0]      WINDOW_RESET    = 7'd20;
    localparam logic [63:0]     NOT_VALID_LOWER = 64'd99999999;

    typedef enum logic [1:0] {
        ALERT_NONE = 2'd0,
        ALERT_BUY  = 2'd1,
        ALERT_SELL = 2'd2
    } t_alert;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIFF,
        ST_CMP,
        ST_DONE
    } t_state;

endpackage

/* rtl/pca_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module pca_ram #(
    parameter int WIDTH = 54,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/price_channel_with_alert_unit.sv */
// Top level of the price channel with latched buy/sell alert.
// Depends on pca_pkg and pca_ram.
`timescale 1ns / 1ps

// Each bar transfer yields one result transfer. Once the channel is formed, a
// bar passes through the SCAN, DIFF, CMP and DONE states, where W is the
// window length in use: the history RAM has one read port with a registered
// output, so the W entries of the window are rescanned one entry per cycle,
// then the DIFF and CMP states form the alert and the DONE state stores the
// bar and loads the output register. Before the channel is formed a bar goes
// straight to the DONE state. The input is not ready while a bar is in work,
// and the DONE state waits while a previous result is still untaken.

module price_channel_with_alert_unit #(
    parameter int MAX_WINDOW = 64,
    parameter int PRICE_BITS = 27
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // Fields from bit 0 up: bar_high, bar_low, bar_close.
    input  logic [((3*PRICE_BITS+7)/8)*8-1:0]         s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // Fields from bit 0 up: channel_valid, upper_band, lower_band, alert_state.
    output logic [((2*PRICE_BITS+3+7)/8)*8-1:0]       m_axis_tdata,
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [pca_pkg::CFG_W-1:0]                 i_cfg_data
);

    localparam int PB    = PRICE_BITS;
    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int WW    = $clog2(MAX_WINDOW + 1);
    localparam int OUT_W = ((2*PRICE_BITS+3+7)/8)*8;
    localparam logic [PB-1:0] LOWER_IDLE = pca_pkg::NOT_VALID_LOWER[PB-1:0];

    pca_pkg::t_state r_state, n_state;
    pca_pkg::t_alert r_alert, n_alert;

    logic [pca_pkg::CFG_W-1:0] r_wl;
    logic [AW-1:0]             r_wp, n_wp, wp_prev, addr_prev;
    logic [WW-1:0]             r_bars, n_bars, win_eff, bars_clamp;
    logic                      acc_valid;

    logic [PB-1:0]             r_hi, r_lo, r_cl;
    logic                      r_chan_valid;
    logic [AW-1:0]             r_addr;
    logic [WW-1:0]             r_left;
    logic                      r_rv, r_first;
    logic [PB-1:0]             r_upper, r_lower, n_upper, n_lower;
    logic signed [PB:0]        r_dcl, r_span, n_dcl, n_span;
    logic signed [PB+3:0]      dc_ext, sp_ext, off, sp4;
    logic                      r_buy, r_sell, n_buy, n_sell;
    logic                      r_ovalid;
    logic [OUT_W-1:0]          r_mdata, n_mdata;

    logic                      accept, scan_issue, fold, out_free, finish;
    logic [2*PB-1:0]           ram_rdata;
    logic [PB-1:0]             rd_hi, rd_lo;

    function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] slot);
        logic [AW-1:0] res;
        if (slot == '0) begin
            res = AW'(MAX_WINDOW - 1);
        end else begin
            res = slot - 1'b1;
        end
        return res;
    endfunction

    pca_ram #(
        .WIDTH (2*PB),
        .DEPTH (MAX_WINDOW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (finish),
        .i_waddr (r_wp),
        .i_wdata ({r_lo, r_hi}),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign rd_hi = ram_rdata[PB-1:0];
    assign rd_lo = ram_rdata[2*PB-1:PB];

    // Control decode.
    always_comb begin
        s_axis_tready = (r_state == pca_pkg::ST_IDLE);
        accept        = s_axis_tvalid && s_axis_tready;
        scan_issue    = (r_state == pca_pkg::ST_SCAN) && (r_left != '0);
        fold          = (r_state == pca_pkg::ST_SCAN) && r_rv;
        out_free      = !r_ovalid || m_axis_tready;
        finish        = (r_state == pca_pkg::ST_DONE) && out_free;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pca_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = acc_valid ? pca_pkg::ST_SCAN : pca_pkg::ST_DONE;
                end
            end
            pca_pkg::ST_SCAN: begin
                if ((r_left == '0) && r_rv) begin
                    n_state = pca_pkg::ST_DIFF;
                end
            end
            pca_pkg::ST_DIFF: n_state = pca_pkg::ST_CMP;
            pca_pkg::ST_CMP:  n_state = pca_pkg::ST_DONE;
            pca_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = pca_pkg::ST_IDLE;
                end
            end
            default: n_state = pca_pkg::ST_IDLE;
        endcase
    end

    // Datapath.
    always_comb begin
        if (r_wl == '0) begin
            win_eff = WW'(1);
        end else if (32'(r_wl) > 32'(MAX_WINDOW)) begin
            win_eff = WW'(MAX_WINDOW);
        end else begin
            win_eff = WW'(r_wl);
        end
        bars_clamp = (r_bars > win_eff) ? win_eff : r_bars;
        acc_valid  = (bars_clamp >= win_eff);
        n_bars     = acc_valid ? win_eff : bars_clamp + 1'b1;

        wp_prev   = prev_slot(r_wp);
        addr_prev = prev_slot(r_addr);
        n_wp      = (r_wp == AW'(MAX_WINDOW - 1)) ? '0 : r_wp + 1'b1;

        if (r_first) begin
            n_upper = rd_hi;
            n_lower = rd_lo;
        end else begin
            n_upper = (rd_hi > r_upper) ? rd_hi : r_upper;
            n_lower = (rd_lo < r_lower) ? rd_lo : r_lower;
        end

        n_dcl = {1'b0, r_cl} - {1'b0, r_lower};
        n_span = {1'b0, r_upper} - {1'b0, r_lower};

        dc_ext = {{3{r_dcl[PB]}}, r_dcl};
        sp_ext = {{3{r_span[PB]}}, r_span};
        off    = (dc_ext <<< 2) + dc_ext;
        sp4    = sp_ext <<< 2;
        n_buy  = (off < sp_ext) || r_dcl[PB];
        n_sell = (off > sp4) || (r_dcl > r_span);

        n_alert = r_alert;
        case (r_alert)
            pca_pkg::ALERT_BUY: begin
                if (r_sell) begin
                    n_alert = pca_pkg::ALERT_SELL;
                end
            end
            pca_pkg::ALERT_SELL: begin
                if (r_buy) begin
                    n_alert = pca_pkg::ALERT_BUY;
                end
            end
            default: begin
                if (r_buy) begin
                    n_alert = pca_pkg::ALERT_BUY;
                end else if (r_sell) begin
                    n_alert = pca_pkg::ALERT_SELL;
                end
            end
        endcase

        n_mdata                 = '0;
        n_mdata[0]              = r_chan_valid;
        n_mdata[PB:1]           = r_upper;
        n_mdata[2*PB:PB+1]      = r_lower;
        n_mdata[2*PB+2:2*PB+1]  = r_chan_valid ? n_alert : r_alert;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pca_pkg::ST_IDLE;
            r_wl     <= pca_pkg::WINDOW_RESET;
            r_wp     <= '0;
            r_bars   <= '0;
            r_alert  <= pca_pkg::ALERT_NONE;
            r_rv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rv    <= scan_issue;
            if (i_cfg_valid) begin
                r_wl <= i_cfg_data;
            end
            if (accept) begin
                r_bars <= n_bars;
            end
            if (finish) begin
                r_wp <= n_wp;
                if (r_chan_valid) begin
                    r_alert <= n_alert;
                end
            end
            if (finish) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hi         <= s_axis_tdata[PB-1:0];
            r_lo         <= s_axis_tdata[2*PB-1:PB];
            r_cl         <= s_axis_tdata[3*PB-1:2*PB];
            r_chan_valid <= acc_valid;
            r_addr       <= wp_prev;
            r_left       <= win_eff;
            r_first      <= 1'b1;
            r_upper      <= '0;
            r_lower      <= LOWER_IDLE;
        end
        if (scan_issue) begin
            r_addr <= addr_prev;
            r_left <= r_left - 1'b1;
        end
        if (fold) begin
            r_first <= 1'b0;
            r_upper <= n_upper;
            r_lower <= n_lower;
        end
        if (r_state == pca_pkg::ST_DIFF) begin
            r_dcl  <= n_dcl;
            r_span <= n_span;
        end
        if (r_state == pca_pkg::ST_CMP) begin
            r_buy  <= n_buy;
            r_sell <= n_sell;
        end
        if (finish) begin
            r_mdata <= n_mdata;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_mdata;
    assign o_cfg_ready   = 1'b1;

endmodule

/* rtl/pca_checker.sv */
// Port-level checks for the price channel with alert unit, bound to the top level.
// Depends on pca_pkg and price_channel_with_alert_unit.
`timescale 1ns / 1ps

module pca_checker #(
    parameter int PRICE_BITS = 27
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [((2*PRICE_BITS+3+7)/8)*8-1:0] m_axis_tdata
);

    localparam int PB = PRICE_BITS;
    localparam logic [PB-1:0] LOWER_IDLE = pca_pkg::NOT_VALID_LOWER[PB-1:0];

    logic [1:0] out_alert;
    assign out_alert = m_axis_tdata[2*PB+2:2*PB+1];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("bar accepted while previous bar still in work");

    a_alert_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (out_alert == pca_pkg::ALERT_NONE) ||
                          (out_alert == pca_pkg::ALERT_BUY) ||
                          (out_alert == pca_pkg::ALERT_SELL))
        else $error("alert field holds an unused code");

    a_unformed_bands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |->
            (m_axis_tdata[PB:1] == '0) && (m_axis_tdata[2*PB:PB+1] == LOWER_IDLE))
        else $error("bands not at their idle values before the channel is formed");

endmodule

bind price_channel_with_alert_unit pca_checker #(
    .PRICE_BITS (PRICE_BITS)
) u_pca_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
